FILE: hdl/cbes_pkg.sv
// shared types, constants and command/status structs for the checkerboard edge swap block
`timescale 1ns / 1ps
package cbes_pkg;

  // sizing
  localparam int MAX_EDGES    = 1024;
  localparam int NUM_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_EDGES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int VTX_W        = $clog2(NUM_VERTICES);
  localparam int PROB_W       = 16;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int EDGE_W       = 2 * VTX_W;

  // configuration reset values
  localparam logic [PROB_W-1:0] SWAP_PROB_RST  = PROB_W'(32768);
  localparam logic [CNT_W-1:0]  EDGE_COUNT_RST = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_SWAP = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_SAME    = 3'd1,
    ST_NOT_CB  = 3'd2,
    ST_REJECT  = 3'd3,
    ST_SWAPPED = 3'd4,
    ST_READ    = 3'd5,
    ST_BAD     = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWAP_PROB  = 1'd0,
    REG_EDGE_COUNT = 1'd1
  } cfg_reg_t;

  // edge memory address / write data source
  typedef enum logic [1:0] {
    EA_IDX = 2'd0,
    EA_PA  = 2'd1,
    EA_PB  = 2'd2
  } edge_sel_t;

  // adjacency row address / write data source
  typedef enum logic [1:0] {
    AR_TV = 2'd0,
    AR_TA = 2'd1,
    AR_TB = 2'd2
  } row_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      in_ready;
    logic      edge_re;
    logic      edge_we;
    edge_sel_t edge_sel;
    logic      adj_re;
    logic      adj_we;
    row_sel_t  row_sel;
    logic      capture_read;
    logic      capture_a;
    logic      capture_b;
    logic      capture_rowa;
    logic      capture_rowb;
    logic      out_load;
    status_t   out_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic idx_ok;
    logic picks_ok;
    logic same_pick;
    logic cross_hit;
    logic draw_ok;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hdl/cbes_req_if.sv
// request channel: one command with its operands
`timescale 1ns / 1ps
interface cbes_req_if
  import cbes_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  edge_index;
  logic [VTX_W-1:0]  tail_vertex;
  logic [VTX_W-1:0]  head_vertex;
  logic [IDX_W-1:0]  pick_a;
  logic [IDX_W-1:0]  pick_b;
  logic [PROB_W-1:0] draw_u;

  modport source (
    output valid, command, edge_index, tail_vertex, head_vertex, pick_a, pick_b, draw_u,
    input  ready
  );
  modport sink (
    input  valid, command, edge_index, tail_vertex, head_vertex, pick_a, pick_b, draw_u,
    output ready
  );
endinterface

FILE: hdl/cbes_rsp_if.sv
// response channel: status and edge read data
`timescale 1ns / 1ps
interface cbes_rsp_if
  import cbes_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VTX_W-1:0]  read_tail;
  logic [VTX_W-1:0]  read_head;

  modport source (
    output valid, status, read_tail, read_head,
    input  ready
  );
  modport sink (
    input  valid, status, read_tail, read_head,
    output ready
  );
endinterface

FILE: hdl/cbes_datapath.sv
// datapath: config registers, edge memory, adjacency row memory, result register
`timescale 1ns / 1ps
module cbes_datapath
  import cbes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  cbes_req_if.sink              req,
  cbes_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  // new row value for a swap: cross bits set first, then old edge bits cleared
  function automatic logic [NUM_VERTICES-1:0] row_update(
    input logic [NUM_VERTICES-1:0] row,
    input logic [VTX_W-1:0]        r,
    input logic [VTX_W-1:0]        ta,
    input logic [VTX_W-1:0]        ha,
    input logic [VTX_W-1:0]        tb,
    input logic [VTX_W-1:0]        hb
  );
    logic [NUM_VERTICES-1:0] v;
    v = row;
    if (r == ta) v[hb] = 1'b1;
    if (r == tb) v[ha] = 1'b1;
    if (r == ta) v[ha] = 1'b0;
    if (r == tb) v[hb] = 1'b0;
    return v;
  endfunction

  logic [PROB_W-1:0] swap_prob;
  logic [CNT_W-1:0]  edge_count;

  // latched request
  cmd_t              cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VTX_W-1:0]  tail_q;
  logic [VTX_W-1:0]  head_q;
  logic [IDX_W-1:0]  pa_q;
  logic [IDX_W-1:0]  pb_q;
  logic [PROB_W-1:0] draw_q;

  // fetched edges and rows
  logic [VTX_W-1:0]        ta, ha, tb, hb;
  logic [VTX_W-1:0]        rt, rh;
  logic [NUM_VERTICES-1:0] rowa, rowb;

  // memories
  logic [EDGE_W-1:0]       edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0]       edge_q;
  logic [NUM_VERTICES-1:0] adj_mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] adj_q;
  logic                    adj_qv;
  logic [NUM_VERTICES-1:0] row_valid;
  logic [NUM_VERTICES-1:0] adj_rdata;

  logic [IDX_W-1:0]        edge_addr;
  logic [EDGE_W-1:0]       edge_wdata;
  logic [VTX_W-1:0]        adj_addr;
  logic [NUM_VERTICES-1:0] adj_wdata;
  logic [NUM_VERTICES-1:0] load_row;

  // result register
  logic              out_valid;
  status_t           out_status;
  logic [VTX_W-1:0]  out_tail;
  logic [VTX_W-1:0]  out_head;

  logic in_xfer;

  assign in_xfer   = req.valid && req.ready;
  assign req.ready = cmd.in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_prob  <= SWAP_PROB_RST;
      edge_count <= EDGE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SWAP_PROB:  swap_prob  <= cfg_wdata[PROB_W-1:0];
        REG_EDGE_COUNT: edge_count <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch and captured operands
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q  <= cmd_t'(req.command);
      idx_q  <= req.edge_index;
      tail_q <= req.tail_vertex;
      head_q <= req.head_vertex;
      pa_q   <= req.pick_a;
      pb_q   <= req.pick_b;
      draw_q <= req.draw_u;
      rt     <= '0;
      rh     <= '0;
    end else if (cmd.capture_read) begin
      rt <= edge_q[EDGE_W-1:VTX_W];
      rh <= edge_q[VTX_W-1:0];
    end
    if (cmd.capture_a) begin
      ta <= edge_q[EDGE_W-1:VTX_W];
      ha <= edge_q[VTX_W-1:0];
    end
    if (cmd.capture_b) begin
      tb <= edge_q[EDGE_W-1:VTX_W];
      hb <= edge_q[VTX_W-1:0];
    end
    if (cmd.capture_rowa) rowa <= adj_rdata;
    if (cmd.capture_rowb) rowb <= adj_rdata;
  end

  // edge memory address and write data
  always_comb begin
    case (cmd.edge_sel)
      EA_PA: begin
        edge_addr  = pa_q;
        edge_wdata = {tb, ha};
      end
      EA_PB: begin
        edge_addr  = pb_q;
        edge_wdata = {ta, hb};
      end
      default: begin
        edge_addr  = idx_q;
        edge_wdata = {tail_q, head_q};
      end
    endcase
  end

  // edge memory, single port
  always_ff @(posedge clk) begin
    if (cmd.edge_we) begin
      edge_mem[edge_addr] <= edge_wdata;
    end else if (cmd.edge_re) begin
      edge_q <= edge_mem[edge_addr];
    end
  end

  // rows never written read as zero
  assign adj_rdata = adj_qv ? adj_q : '0;

  // adjacency row address and write data
  always_comb begin
    load_row         = adj_rdata;
    load_row[head_q] = 1'b1;
    case (cmd.row_sel)
      AR_TA: begin
        adj_addr  = ta;
        adj_wdata = row_update(rowa, ta, ta, ha, tb, hb);
      end
      AR_TB: begin
        adj_addr  = tb;
        adj_wdata = row_update(rowb, tb, ta, ha, tb, hb);
      end
      default: begin
        adj_addr  = tail_q;
        adj_wdata = load_row;
      end
    endcase
  end

  // adjacency row memory, single port
  always_ff @(posedge clk) begin
    if (cmd.adj_we) begin
      adj_mem[adj_addr] <= adj_wdata;
    end else if (cmd.adj_re) begin
      adj_q <= adj_mem[adj_addr];
    end
  end

  // per-row valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      adj_qv    <= 1'b0;
    end else begin
      if (cmd.adj_we) begin
        row_valid[adj_addr] <= 1'b1;
      end else if (cmd.adj_re) begin
        adj_qv <= row_valid[adj_addr];
      end
    end
  end

  // result register, holds until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_tail   <= rt;
      out_head   <= rh;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.read_tail = out_tail;
  assign rsp.read_head = out_head;

  // status toward the controller
  assign stat.in_valid  = req.valid;
  assign stat.cmd       = cmd_q;
  assign stat.idx_ok    = {1'b0, idx_q} < edge_count;
  assign stat.picks_ok  = ({1'b0, pa_q} < edge_count) && ({1'b0, pb_q} < edge_count);
  assign stat.same_pick = pa_q == pb_q;
  assign stat.cross_hit = rowa[hb] || adj_rdata[ha];
  assign stat.draw_ok   = draw_q < swap_prob;
  assign stat.out_busy  = out_valid && !rsp.ready;

endmodule

FILE: hdl/cbes_ctrl.sv
// controller: sequences loads, reads and swaps over the single-port memories
`timescale 1ns / 1ps
module cbes_ctrl
  import cbes_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LD_WR,
    S_RD_WAIT,
    S_SW_RDB,
    S_SW_ROWA,
    S_SW_ROWB,
    S_SW_CHECK,
    S_SW_WRA,
    S_SW_WRB,
    S_FINISH
  } state_t;

  state_t  state, state_next;
  status_t res_status, res_status_next;

  // next state and datapath commands
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    cmd.edge_sel    = EA_IDX;
    cmd.row_sel     = AR_TV;
    cmd.out_status  = res_status;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_status_next = ST_BAD;
        state_next      = S_FINISH;
        case (stat.cmd)
          CMD_LOAD: begin
            if (stat.idx_ok) begin
              cmd.edge_we = 1'b1;
              cmd.adj_re  = 1'b1;
              state_next  = S_LD_WR;
            end
          end
          CMD_READ: begin
            if (stat.idx_ok) begin
              cmd.edge_re = 1'b1;
              state_next  = S_RD_WAIT;
            end
          end
          CMD_SWAP: begin
            if (stat.picks_ok) begin
              if (stat.same_pick) begin
                res_status_next = ST_SAME;
              end else begin
                cmd.edge_re  = 1'b1;
                cmd.edge_sel = EA_PA;
                state_next   = S_SW_RDB;
              end
            end
          end
          default: ;
        endcase
      end
      S_LD_WR: begin
        cmd.adj_we      = 1'b1;
        res_status_next = ST_LOADED;
        state_next      = S_FINISH;
      end
      S_RD_WAIT: begin
        cmd.capture_read = 1'b1;
        res_status_next  = ST_READ;
        state_next       = S_FINISH;
      end
      S_SW_RDB: begin
        cmd.capture_a = 1'b1;
        cmd.edge_re   = 1'b1;
        cmd.edge_sel  = EA_PB;
        state_next    = S_SW_ROWA;
      end
      S_SW_ROWA: begin
        cmd.capture_b = 1'b1;
        cmd.adj_re    = 1'b1;
        cmd.row_sel   = AR_TA;
        state_next    = S_SW_ROWB;
      end
      S_SW_ROWB: begin
        cmd.capture_rowa = 1'b1;
        cmd.adj_re       = 1'b1;
        cmd.row_sel      = AR_TB;
        state_next       = S_SW_CHECK;
      end
      S_SW_CHECK: begin
        cmd.capture_rowb = 1'b1;
        if (stat.cross_hit) begin
          res_status_next = ST_NOT_CB;
          state_next      = S_FINISH;
        end else if (!stat.draw_ok) begin
          res_status_next = ST_REJECT;
          state_next      = S_FINISH;
        end else begin
          state_next = S_SW_WRA;
        end
      end
      S_SW_WRA: begin
        cmd.adj_we   = 1'b1;
        cmd.row_sel  = AR_TA;
        cmd.edge_we  = 1'b1;
        cmd.edge_sel = EA_PA;
        state_next   = S_SW_WRB;
      end
      S_SW_WRB: begin
        cmd.adj_we      = 1'b1;
        cmd.row_sel     = AR_TB;
        cmd.edge_we     = 1'b1;
        cmd.edge_sel    = EA_PB;
        res_status_next = ST_SWAPPED;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_BAD;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

FILE: hdl/checkerboard_edge_swap_top.sv
// top level of the checkerboard edge swap engine
//
//   channel  dir   handshake       payload
//   req      in    valid / ready   command, edge_index, tail/head_vertex, pick_a/b, draw_u
//   rsp      out   valid / ready   status, read_tail, read_head
//   cfg      in    cfg_we          cfg_index, cfg_wdata
//
// one command at a time; a bad index or same pick finishes at once, and a swap that fails
// its check skips the write-backs. the single-port edge memory and adjacency row memory
// serialize the edge reads and row probes for both picks and the write-backs of both.
// the adjacency rows carry valid bits cleared by reset, so no clearing pass is needed.
// a finished result waits in the output register; the next request is taken meanwhile,
// and its result holds the controller until the waiting one is transferred.
`timescale 1ns / 1ps
module checkerboard_edge_swap_top
  import cbes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  cbes_req_if.sink              req,
  cbes_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  cbes_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (dp_stat),
    .cmd  (dp_cmd)
  );

  cbes_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // memory writes only happen while a command is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.adj_we || dp_cmd.edge_we) |-> !req.ready)
    else $error("memory write while idle");

  // no result appears in the cycle right after a request transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !$rose(rsp.valid))
    else $error("result too early");

endmodule

FILE: test/tb_checkerboard_edge_swap_top.sv
// self-checking testbench for the checkerboard edge swap top level
`timescale 1ns / 1ps
module tb_checkerboard_edge_swap_top;
  import cbes_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  edge_index;
    logic [VTX_W-1:0]  tail_vertex;
    logic [VTX_W-1:0]  head_vertex;
    logic [IDX_W-1:0]  pick_a;
    logic [IDX_W-1:0]  pick_b;
    logic [PROB_W-1:0] draw_u;
  } edge_req_t;

  typedef struct packed {
    status_t          status;
    logic [VTX_W-1:0] read_tail;
    logic [VTX_W-1:0] read_head;
  } edge_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cbes_req_if req_ch ();
  cbes_rsp_if rsp_ch ();

  checkerboard_edge_swap_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // commands waiting to be driven and results waiting to come back
  edge_req_t    cmd_backlog[$];
  edge_result_t predicted_rsps[$];

  int err_count = 0;
  int idle_mode = IDLE_NONE;
  int idle_cycles = 0;
  bit req_taken = 1'b0;

  // shadow of the block: edge list, adjacency bitmap, registers
  logic [VTX_W-1:0]              pred_tail [0:MAX_EDGES-1];
  logic [VTX_W-1:0]              pred_head [0:MAX_EDGES-1];
  bit [NUM_VERTICES*NUM_VERTICES-1:0] pred_adj;
  logic [PROB_W-1:0]             pred_prob;
  logic [CNT_W-1:0]              pred_count;

  // stimulus side bookkeeping of which slots hold an edge
  bit gen_written [0:MAX_EDGES-1];
  int gen_list[$];
  int gen_count = 0;
  int gen_prob = 32768;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic bit slot_valid(logic [IDX_W-1:0] i);
    return {1'b0, i} < pred_count;
  endfunction

  // one command against the shadow state
  function automatic edge_result_t predict_edge_op(edge_req_t r);
    edge_result_t res;
    logic [VTX_W-1:0] ta, ha, tb, hb;
    res = '{status: ST_BAD, read_tail: '0, read_head: '0};
    case (r.command)
      CMD_LOAD: begin
        if (slot_valid(r.edge_index)) begin
          pred_tail[r.edge_index] = r.tail_vertex;
          pred_head[r.edge_index] = r.head_vertex;
          pred_adj[{r.tail_vertex, r.head_vertex}] = 1'b1;
          res.status = ST_LOADED;
        end
      end
      CMD_SWAP: begin
        if (slot_valid(r.pick_a) && slot_valid(r.pick_b)) begin
          if (r.pick_a == r.pick_b) begin
            res.status = ST_SAME;
          end else begin
            ta = pred_tail[r.pick_a];
            ha = pred_head[r.pick_a];
            tb = pred_tail[r.pick_b];
            hb = pred_head[r.pick_b];
            if (pred_adj[{ta, hb}] || pred_adj[{tb, ha}]) begin
              res.status = ST_NOT_CB;
            end else if (r.draw_u >= pred_prob) begin
              res.status = ST_REJECT;
            end else begin
              // cross bits set first, then the old pair bits cleared
              pred_adj[{ta, hb}] = 1'b1;
              pred_adj[{tb, ha}] = 1'b1;
              pred_adj[{ta, ha}] = 1'b0;
              pred_adj[{tb, hb}] = 1'b0;
              pred_tail[r.pick_a] = tb;
              pred_tail[r.pick_b] = ta;
              res.status = ST_SWAPPED;
            end
          end
        end
      end
      CMD_READ: begin
        if (slot_valid(r.edge_index)) begin
          res.read_tail = pred_tail[r.edge_index];
          res.read_head = pred_head[r.edge_index];
          res.status = ST_READ;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // predictor, result checker and watchdog on the rising edge
  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      pred_prob = SWAP_PROB_RST;
      pred_count = EDGE_COUNT_RST;
      pred_adj = '0;
      req_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SWAP_PROB:  pred_prob = cfg_wdata[PROB_W-1:0];
          REG_EDGE_COUNT: pred_count = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        predicted_rsps.push_back(predict_edge_op('{
          command: req_ch.command, edge_index: req_ch.edge_index,
          tail_vertex: req_ch.tail_vertex, head_vertex: req_ch.head_vertex,
          pick_a: req_ch.pick_a, pick_b: req_ch.pick_b, draw_u: req_ch.draw_u}));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_rsps.size() == 0) begin
          report_mismatch("status of a result with no command pending", 8'(rsp_ch.status),
                          8'd0);
        end else begin
          want = predicted_rsps.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 8'(rsp_ch.status), 8'(want.status));
          if (rsp_ch.read_tail !== want.read_tail)
            report_mismatch("read_tail", 8'(rsp_ch.read_tail), 8'(want.read_tail));
          if (rsp_ch.read_head !== want.read_head)
            report_mismatch("read_head", 8'(rsp_ch.read_head), 8'(want.read_head));
        end
      end
      // watchdog on cycles without any transfer
      if (req_taken || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("tb_checkerboard_edge_swap_top NOT OK");
        $finish;
      end
    end
  end

  function automatic bit idle_roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // request driver and response ready on the falling edge
  always @(negedge clk) begin
    edge_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_taken) begin
        if (cmd_backlog.size() > 0 &&
            !idle_roll(idle_mode == IDLE_SEND ? 63 : idle_mode == IDLE_BOTH ? 35 : 0)) begin
          nxt = cmd_backlog.pop_front();
          req_ch.command     <= nxt.command;
          req_ch.edge_index  <= nxt.edge_index;
          req_ch.tail_vertex <= nxt.tail_vertex;
          req_ch.head_vertex <= nxt.head_vertex;
          req_ch.pick_a      <= nxt.pick_a;
          req_ch.pick_b      <= nxt.pick_b;
          req_ch.draw_u      <= nxt.draw_u;
          req_ch.valid       <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= !idle_roll(idle_mode == IDLE_RECV ? 63 : idle_mode == IDLE_BOTH ? 35 : 0);
    end
  end

  task automatic queue_item(logic [CMD_W-1:0] cmd, int idx, int t, int h, int pa, int pb,
                            int draw);
    edge_req_t r;
    r.command     = cmd;
    r.edge_index  = IDX_W'(idx);
    r.tail_vertex = VTX_W'(t);
    r.head_vertex = VTX_W'(h);
    r.pick_a      = IDX_W'(pa);
    r.pick_b      = IDX_W'(pb);
    r.draw_u      = PROB_W'(draw);
    if (cmd == CMD_LOAD && idx < gen_count && !gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      gen_list.push_back(idx);
    end
    cmd_backlog.push_back(r);
  endtask

  // a loaded slot that is valid under the current edge count, or -1
  function automatic int pick_loaded_slot();
    int k;
    if (gen_list.size() == 0) return -1;
    repeat (16) begin
      k = gen_list[$urandom_range(gen_list.size() - 1)];
      if (k < gen_count) return k;
    end
    foreach (gen_list[i]) if (gen_list[i] < gen_count) return gen_list[i];
    return -1;
  endfunction

  // mostly meaningful commands on loaded slots, some invalid ones and noise
  task automatic queue_random_item(int vmax);
    int roll, sub, a, b, idx, draw;
    roll = $urandom_range(99);
    a = pick_loaded_slot();
    idx = $urandom_range(MAX_EDGES - 1);
    draw = $urandom_range(65535);
    if (roll < 30 || a < 0) begin
      if (gen_count > 0) idx = (a >= 0 && $urandom_range(1)) ? a : $urandom_range(gen_count - 1);
      queue_item(CMD_LOAD, idx, $urandom_range(vmax), $urandom_range(vmax),
                 $urandom_range(1023), $urandom_range(1023), draw);
    end else if (roll < 75) begin
      sub = $urandom_range(99);
      if (sub < 8) b = a;
      else if (sub < 20 && gen_count < MAX_EDGES) b = $urandom_range(MAX_EDGES - 1, gen_count);
      else b = pick_loaded_slot();
      // draws right at the probability boundary
      sub = $urandom_range(3);
      if (sub == 1) draw = (gen_prob + 65535) % 65536;
      else if (sub == 2) draw = gen_prob;
      if ($urandom_range(1))
        queue_item(CMD_SWAP, idx, $urandom_range(63), $urandom_range(63), a, b, draw);
      else
        queue_item(CMD_SWAP, idx, $urandom_range(63), $urandom_range(63), b, a, draw);
    end else if (roll < 93) begin
      b = (gen_count < MAX_EDGES && $urandom_range(9) == 0) ?
          $urandom_range(MAX_EDGES - 1, gen_count) : a;
      queue_item(CMD_READ, b, $urandom_range(63), $urandom_range(63),
                 $urandom_range(1023), $urandom_range(1023), draw);
    end else if (gen_count < MAX_EDGES && $urandom_range(1)) begin
      queue_item(CMD_LOAD, $urandom_range(MAX_EDGES - 1, gen_count), $urandom_range(63),
                 $urandom_range(63), $urandom_range(1023), $urandom_range(1023), draw);
    end else begin
      queue_item(CMD_UNKNOWN, idx, $urandom_range(63), $urandom_range(63),
                 $urandom_range(1023), $urandom_range(1023), draw);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (!(cmd_backlog.size() == 0 && !req_ch.valid && predicted_rsps.size() == 0));
  endtask

  task automatic write_reg(cfg_reg_t which, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (which == REG_SWAP_PROB) gen_prob = value;
    else gen_count = value;
  endtask

  // phases: settings, idling and vertex range per phase; -1 asks for a random value
  initial begin
    int ph_mode  [8] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                         IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    int ph_prob  [8] = '{65535, 32768, 0, -1, 1, -1, 40000, 65535};
    int ph_count [8] = '{1024, 40, 1024, -1, 1, 200, 16, 1024};
    int ph_vmax  [8] = '{63, 7, 15, 7, 63, 31, 3, 63};
    int ph_items [8] = '{90, 90, 80, 90, 60, 100, 100, 90};

    req_ch.valid = 1'b0;
    req_ch.command = '0;
    req_ch.edge_index = '0;
    req_ch.tail_vertex = '0;
    req_ch.head_vertex = '0;
    req_ch.pick_a = '0;
    req_ch.pick_b = '0;
    req_ch.draw_u = '0;
    rsp_ch.ready = 1'b0;
    foreach (gen_written[i]) gen_written[i] = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edge count zero after reset: everything is a bad index
    queue_item(CMD_LOAD, 0, 1, 2, 0, 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_SWAP, 0, 0, 0, 0, 1, 0);
    queue_item(CMD_UNKNOWN, 1023, 63, 63, 1023, 1023, 65535);
    wait_drained();
    write_reg(REG_EDGE_COUNT, 1024);

    // small graph: same pick, cross edge present, boundary draws, reload
    queue_item(CMD_LOAD, 0, 1, 2, 0, 0, 0);
    queue_item(CMD_LOAD, 1, 3, 4, 0, 0, 0);
    queue_item(CMD_LOAD, 1023, 63, 63, 0, 0, 0);
    queue_item(CMD_LOAD, 2, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 3, 1, 4, 0, 0, 0);
    queue_item(CMD_LOAD, 4, 3, 2, 0, 0, 0);
    queue_item(CMD_SWAP, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_SWAP, 0, 0, 0, 0, 1, 0);
    queue_item(CMD_SWAP, 0, 0, 0, 2, 1023, 0);
    queue_item(CMD_SWAP, 0, 0, 0, 0, 1023, 32768);
    queue_item(CMD_SWAP, 0, 0, 0, 0, 1023, 32767);
    queue_item(CMD_READ, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_READ, 1023, 0, 0, 0, 0, 0);
    queue_item(CMD_READ, 2, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 0, 10, 20, 0, 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_EDGE_COUNT, 5);
    write_reg(REG_SWAP_PROB, 0);

    // shrunken edge count and zero probability
    queue_item(CMD_SWAP, 0, 0, 0, 0, 1023, 0);
    queue_item(CMD_READ, 1023, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 1023, 5, 5, 0, 0, 0);
    queue_item(CMD_SWAP, 0, 0, 0, 1, 4, 0);
    queue_item(CMD_READ, 4, 0, 0, 0, 0, 0);

    // random phases, each starting from an idle block
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_reg(REG_SWAP_PROB, ph_prob[p] < 0 ? $urandom_range(65535) : ph_prob[p]);
      write_reg(REG_EDGE_COUNT, ph_count[p] < 0 ? $urandom_range(MAX_EDGES, 1) : ph_count[p]);
      idle_mode = ph_mode[p];
      repeat (ph_items[p]) queue_random_item(ph_vmax[p]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_checkerboard_edge_swap_top OK");
    end else begin
      $display("tb_checkerboard_edge_swap_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/cbes_pkg.sv
hdl/cbes_req_if.sv
hdl/cbes_rsp_if.sv
hdl/cbes_datapath.sv
hdl/cbes_ctrl.sv
hdl/checkerboard_edge_swap_top.sv
test/tb_checkerboard_edge_swap_top.sv
